>>> sv/slt_pkg.sv
// Package with the operation and status codes of the slot table.
package slt_pkg;

   // Fixed field widths of the request and response words.
   localparam int MODE_BITS   = 2;
   localparam int POS_BITS    = 4;
   localparam int VALUE_W     = 32;
   localparam int STATUS_BITS = 2;
   localparam int TOTAL_BITS  = 5;

   // Operation codes carried by a request word.
   typedef enum logic [MODE_BITS-1:0] {
      MODE_INSERT = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_READ   = 2'd2,
      MODE_TAKE   = 2'd3
   } mode_type;

   // Status codes carried by a response word.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

>>> sv/slt_first_free.sv
// Priority encoder that finds the lowest-numbered empty slot.
module slt_first_free
   import slt_pkg::*;
#(
   parameter int SLOTS    = 16,
   parameter int IDX_BITS = 4
) (
   input  logic [SLOTS-1:0]    occupied,
   output logic                found,
   output logic [IDX_BITS-1:0] free_idx
);

   // Scan from the top down so that the lowest empty slot wins.
   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!occupied[i]) begin
            found    = 1'b1;
            free_idx = IDX_BITS'(i);
         end
      end
   end

endmodule

>>> sv/slt_value_ram.sv
// Single-port value memory with registered read data.
module slt_value_ram
   import slt_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = 4,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [DATA_BITS-1:0] wr_data,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write the addressed entry; the read returns the old content.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/slot_table_first_free_core.sv
// Top level of the slot table with first-free insert.
//
//   Channel   Ports                                  Handshake
//   request   req_mode, req_position, req_value_in   start high and busy low
//   response  rsp_status, rsp_value_out,             rsp_valid for one cycle
//             rsp_slot_used, rsp_occupied_total
//
// A request word is taken in every cycle; busy is always low. The response
// appears in the cycle after the request, when the registered memory read and the
// decision registers are ready. Occupancy flags and the count update at the
// accept edge, so the next word sees them at once. Reset clears the occupancy
// flags and the count; the value memory needs no clearing.
// The receiver cannot stall, so no response is ever held.
module slot_table_first_free_core
   import slt_pkg::*;
#(
   parameter int SLOTS      = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [MODE_BITS-1:0]   req_mode,
   input  logic [POS_BITS-1:0]    req_position,
   input  logic [VALUE_W-1:0]     req_value_in,
   output logic                   rsp_valid,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [VALUE_W-1:0]     rsp_value_out,
   output logic [POS_BITS-1:0]    rsp_slot_used,
   output logic [TOTAL_BITS-1:0]  rsp_occupied_total
);

   localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_BITS = $clog2(SLOTS + 1);

   logic                  accept;
   mode_type              mode;
   logic [8:0]            pos_ext;
   logic                  in_range;
   logic [IDX_BITS-1:0]   pos_addr;
   logic [63:0]           val_ext;
   logic [VALUE_BITS-1:0] val;
   logic                  val_nz;
   logic                  found;
   logic [IDX_BITS-1:0]   free_idx;
   logic [8:0]            free_ext;
   logic                  ins_store;
   logic                  wr_store;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [IDX_BITS-1:0]   ram_addr;
   logic [VALUE_BITS-1:0] ram_rd_data;
   logic [63:0]           rd_ext;
   logic [8:0]            cnt_ext;

   logic [SLOTS-1:0]       occ_ff, occ_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   rsp_valid_ff;
   status_type             status_ff, status_in;
   logic [POS_BITS-1:0]    slot_ff, slot_in;
   logic                   hit_ff, hit_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign mode   = mode_type'(req_mode);

   // Position decode and value masking.
   assign pos_ext  = 9'(req_position);
   assign in_range = pos_ext < 9'(SLOTS);
   assign pos_addr = pos_ext[IDX_BITS-1:0];
   assign val_ext  = 64'(req_value_in);
   assign val      = val_ext[VALUE_BITS-1:0];
   assign val_nz   = val != '0;

   slt_first_free #(
      .SLOTS    (SLOTS),
      .IDX_BITS (IDX_BITS)
   ) u_first_free (
      .occupied (occ_ff),
      .found    (found),
      .free_idx (free_idx)
   );

   assign free_ext = 9'(free_idx);

   // Only non-zero values reach the memory; empty slots read as zero by flag.
   assign ins_store = (mode == MODE_INSERT) && found && val_nz;
   assign wr_store  = (mode == MODE_WRITE) && in_range && val_nz;
   assign ram_wr_en = accept && (ins_store || wr_store);
   assign ram_rd_en = accept;
   assign ram_addr  = (mode == MODE_INSERT) ? free_idx : pos_addr;

   slt_value_ram #(
      .DEPTH     (SLOTS),
      .ADDR_BITS (IDX_BITS),
      .DATA_BITS (VALUE_BITS)
   ) u_value_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .wr_en   (ram_wr_en),
      .addr    (ram_addr),
      .wr_data (val),
      .rd_data (ram_rd_data)
   );

   // Decide the occupancy, count and response fields of one request.
   always_comb begin
      occ_in    = occ_ff;
      cnt_in    = cnt_ff;
      status_in = ST_OK;
      slot_in   = req_position;
      hit_in    = 1'b0;
      case (mode)
         MODE_INSERT: begin
            if (found) begin
               slot_in = free_ext[POS_BITS-1:0];
               if (val_nz) begin
                  occ_in[free_idx] = 1'b1;
                  cnt_in           = cnt_ff + CNT_BITS'(1);
               end
            end else begin
               slot_in   = '0;
               status_in = ST_FULL;
            end
         end
         MODE_WRITE: begin
            if (in_range) begin
               occ_in[pos_addr] = val_nz;
               if (occ_ff[pos_addr] && !val_nz) begin
                  cnt_in = cnt_ff - CNT_BITS'(1);
               end else if (!occ_ff[pos_addr] && val_nz) begin
                  cnt_in = cnt_ff + CNT_BITS'(1);
               end
            end
         end
         default: begin
            if (in_range && occ_ff[pos_addr]) begin
               hit_in = 1'b1;
               if (mode == MODE_TAKE) begin
                  occ_in[pos_addr] = 1'b0;
                  cnt_in           = cnt_ff - CNT_BITS'(1);
               end
            end else begin
               status_in = ST_EMPTY;
            end
         end
      endcase
   end

   // Table state and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            occ_ff <= occ_in;
            cnt_ff <= cnt_in;
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         hit_ff    <= hit_in;
      end
   end

   // Drive the response word.
   assign rd_ext             = 64'(ram_rd_data);
   assign cnt_ext            = 9'(cnt_ff);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_value_out      = hit_ff ? rd_ext[VALUE_W-1:0] : '0;
   assign rsp_slot_used      = slot_ff;
   assign rsp_occupied_total = cnt_ext[TOTAL_BITS-1:0];

endmodule

>>> sv/slt_checker.sv
// Port-level checker for the slot table, bound to the top level.
module slt_checker
   import slt_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic [STATUS_BITS-1:0] rsp_status,
   input logic [VALUE_W-1:0]     rsp_value_out,
   input logic [POS_BITS-1:0]    rsp_slot_used,
   input logic [TOTAL_BITS-1:0]  rsp_occupied_total
);

   // Every accepted word gives one response in the following cycle.
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(start && !busy && !reset))
      else $error("response strobe does not follow accepted word");

   // A full table reports every slot occupied.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |->
         rsp_occupied_total == TOTAL_BITS'(SLOTS))
      else $error("full status with a count below the table size");

   // A full insert returns slot zero and no value.
   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |->
         (rsp_slot_used == '0 && rsp_value_out == '0))
      else $error("full status with slot or value set");

   // A non-zero value is only returned with an ok status.
   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_value_out != '0) |-> rsp_status == ST_OK)
      else $error("value returned with a failing status");

   // The status field never carries the unused code.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_status == ST_OK || rsp_status == ST_EMPTY || rsp_status == ST_FULL))
      else $error("unused status code");

endmodule

bind slot_table_first_free_core slt_checker #(.SLOTS(SLOTS)) u_slt_checker (.*);
